// ----- rtl/trc_pkg.sv -----
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, codes and widths of the tape record controller.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int ADDR_W     = 20;
   localparam int DATA_W     = 8;
   localparam int OP_W       = 2;
   localparam int ORDER_W    = 8;
   localparam int POS_W      = 21;
   localparam int CAP_W      = 7;
   localparam int LEN_W      = 16;
   localparam int NIB_W      = 4;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 21;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_COMMAND = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;
   localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

   localparam logic [ORDER_W-1:0] ORD_REWIND    = 8'h20;
   localparam logic [ORDER_W-1:0] ORD_BACKSPACE = 8'h24;
   localparam logic [ORDER_W-1:0] ORD_FORWARD   = 8'h28;

   localparam logic [STATUS_W-1:0] ST_END          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_END       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_POSSIBLE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_LENGTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_CAPACITY = 1'd1;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_LOAD      = 3'd0;
   localparam kind_type KIND_REWIND    = 3'd1;
   localparam kind_type KIND_BACKSPACE = 3'd2;
   localparam kind_type KIND_FORWARD   = 3'd3;
   localparam kind_type KIND_OTHER     = 3'd4;
   localparam kind_type KIND_READ      = 3'd5;
   localparam kind_type KIND_WRITE     = 3'd6;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   data;
   } entry_type;

   typedef struct packed {
      logic       valid;
      entry_type  entry;
   } head_type;

   typedef struct packed {
      logic                  valid;
      logic [STATUS_W-1:0]   status;
      logic [NIB_W-1:0]      nibble;
      logic                  nibble_valid;
      logic [COUNT_W-1:0]    nibble_count;
      logic                  last;
   } rsp_type;

endpackage

// ----- rtl/trc_front.sv -----
// ----------------------------------------------------------------------------
// trc_front
// Accepts request words and classifies them into work kinds for the queue.
// ----------------------------------------------------------------------------
module trc_front (
   input  logic                         start,
   input  logic                         full,
   input  logic [trc_pkg::OP_W-1:0]     req_operation,
   input  logic [trc_pkg::ORDER_W-1:0]  req_order,
   input  logic [trc_pkg::ADDR_W-1:0]   req_address,
   input  logic [trc_pkg::DATA_W-1:0]   req_data,
   output logic                         busy,
   output logic                         push,
   output trc_pkg::entry_type           push_entry
);
   import trc_pkg::*;

   kind_type kind;

   always_comb begin
      kind = KIND_OTHER;
      unique case (req_operation)
         OP_LOAD: begin
            kind = KIND_LOAD;
         end
         OP_COMMAND: begin
            priority if (req_order == ORD_REWIND) begin
               kind = KIND_REWIND;
            end else if (req_order == ORD_BACKSPACE) begin
               kind = KIND_BACKSPACE;
            end else if (req_order == ORD_FORWARD) begin
               kind = KIND_FORWARD;
            end else begin
               kind = KIND_OTHER;
            end
         end
         OP_READ: begin
            kind = KIND_READ;
         end
         OP_WRITE: begin
            kind = KIND_WRITE;
         end
         default: begin
            kind = KIND_OTHER;
         end
      endcase
   end

   assign busy               = full;
   assign push               = start && !full;
   assign push_entry.kind    = kind;
   assign push_entry.address = req_address;
   assign push_entry.data    = req_data;

endmodule

// ----- rtl/trc_queue.sv -----
// ----------------------------------------------------------------------------
// trc_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module trc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  trc_pkg::entry_type  push_entry,
   input  logic                pop,
   output trc_pkg::head_type   head,
   output logic                full
);
   import trc_pkg::*;

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff;
   logic [QCNT_W-1:0]    count_in;
   logic                 do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/trc_back.sv -----
// ----------------------------------------------------------------------------
// trc_back
// Carries out queued words: image store, tape positions and record reads.
// ----------------------------------------------------------------------------
module trc_back #(
   parameter int IMAGE_BYTES      = 1048576,
   parameter int MAX_READ_NIBBLES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  trc_pkg::head_type              head,
   input  logic [trc_pkg::POS_W-1:0]      image_length,
   input  logic [trc_pkg::CAP_W-1:0]      read_capacity,
   output logic                           pop,
   output trc_pkg::rsp_type               rsp
);
   import trc_pkg::*;

   localparam int AW = $clog2(IMAGE_BYTES);
   localparam int LW = (AW + 1 > 23) ? AW + 1 : 23;
   localparam int BW = $clog2(MAX_READ_NIBBLES / 2 + 1);
   localparam logic [LW-1:0]    IMG_L   = LW'(IMAGE_BYTES);
   localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_READ_NIBBLES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LEN_HI = 3'd1;
   localparam logic [2:0] S_LEN_LO = 3'd2;
   localparam logic [2:0] S_NIB_HI = 3'd3;
   localparam logic [2:0] S_NIB_LO = 3'd4;

   logic [DATA_W-1:0]   mem [IMAGE_BYTES];
   logic [DATA_W-1:0]   rd_data_ff;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [POS_W-1:0]    prev_ff;
   logic [POS_W-1:0]    prev_in;
   logic                is_read_ff;
   logic                is_read_in;
   logic [DATA_W-1:0]   len_hi_ff;
   logic [DATA_W-1:0]   len_hi_in;
   logic [LEN_W-1:0]    len_ff;
   logic [LEN_W-1:0]    len_in;
   logic [LW-1:0]       baddr_ff;
   logic [LW-1:0]       baddr_in;
   logic [BW-1:0]       bcount_ff;
   logic [BW-1:0]       bcount_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [LW-1:0]       lim;
   logic [LW-1:0]       pos_l;
   logic [LW-1:0]       base;
   logic [LW-1:0]       baddr_next;
   logic                len_ok;
   logic [CAP_W-1:0]    cap;
   logic [COUNT_W-1:0]  byte_cap;
   logic [LEN_W-1:0]    full_len;
   logic [BW-1:0]       bcount_next;
   logic                first_ok;
   logic                more_ok;
   logic [LW-1:0]       waddr_l;
   logic                mem_we;
   logic                mem_re;
   logic [LW-1:0]       raddr_l;

   assign lim        = (LW'(image_length) > IMG_L) ? IMG_L : LW'(image_length);
   assign pos_l      = LW'(pos_ff);
   assign base       = pos_l + LW'(2);
   assign len_ok     = base <= lim;
   assign cap        = (read_capacity > CAP_MAX) ? CAP_MAX : read_capacity;
   assign byte_cap   = COUNT_W'(cap >> 1);
   assign full_len   = {len_hi_ff, rd_data_ff};
   assign first_ok   = (full_len != '0) && (base < lim) && (byte_cap != '0);
   assign bcount_next = bcount_ff + 1'b1;
   assign baddr_next  = baddr_ff + LW'(1);
   assign more_ok    = (LEN_W'(bcount_next) < len_ff) && (baddr_next < lim)
                       && (COUNT_W'(bcount_next) < byte_cap);
   assign waddr_l    = LW'(head.entry.address);
   assign pop        = (state_ff == S_IDLE) && head.valid;
   assign rsp        = rsp_ff;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      prev_in    = prev_ff;
      is_read_in = is_read_ff;
      len_hi_in  = len_hi_ff;
      len_in     = len_ff;
      baddr_in   = baddr_ff;
      bcount_in  = bcount_ff;
      rsp_in     = '0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      raddr_l    = pos_l;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               unique case (head.entry.kind)
                  KIND_LOAD: begin
                     mem_we = waddr_l < IMG_L;
                  end
                  KIND_REWIND: begin
                     prev_in       = pos_ff;
                     pos_in        = '0;
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = ST_END;
                     rsp_in.last   = 1'b1;
                  end
                  KIND_BACKSPACE: begin
                     pos_in        = prev_ff;
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = ST_END;
                     rsp_in.last   = 1'b1;
                  end
                  KIND_WRITE: begin
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = ST_NOT_POSSIBLE;
                     rsp_in.last   = 1'b1;
                  end
                  KIND_FORWARD, KIND_READ: begin
                     if (len_ok) begin
                        mem_re     = 1'b1;
                        raddr_l    = pos_l;
                        is_read_in = (head.entry.kind == KIND_READ);
                        state_in   = S_LEN_HI;
                     end else begin
                        rsp_in.valid  = 1'b1;
                        rsp_in.status = ST_NOT_POSSIBLE;
                        rsp_in.last   = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = ST_NO_END;
                     rsp_in.last   = 1'b1;
                  end
               endcase
            end
         end
         S_LEN_HI: begin
            len_hi_in = rd_data_ff;
            mem_re    = 1'b1;
            raddr_l   = pos_l + LW'(1);
            state_in  = S_LEN_LO;
         end
         S_LEN_LO: begin
            len_in = full_len;
            if (is_read_ff && first_ok) begin
               mem_re    = 1'b1;
               raddr_l   = base;
               baddr_in  = base;
               bcount_in = '0;
               state_in  = S_NIB_HI;
            end else begin
               prev_in       = pos_ff;
               pos_in        = pos_ff + POS_W'(2) + POS_W'(full_len);
               rsp_in.valid  = 1'b1;
               rsp_in.status = ST_END;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_NIB_HI: begin
            rsp_in.valid        = 1'b1;
            rsp_in.status       = ST_END;
            rsp_in.nibble       = rd_data_ff[7:4];
            rsp_in.nibble_valid = 1'b1;
            state_in            = S_NIB_LO;
         end
         S_NIB_LO: begin
            rsp_in.valid        = 1'b1;
            rsp_in.status       = ST_END;
            rsp_in.nibble       = rd_data_ff[3:0];
            rsp_in.nibble_valid = 1'b1;
            if (more_ok) begin
               mem_re    = 1'b1;
               raddr_l   = baddr_next;
               baddr_in  = baddr_next;
               bcount_in = bcount_next;
               state_in  = S_NIB_HI;
            end else begin
               rsp_in.last         = 1'b1;
               rsp_in.nibble_count = COUNT_W'({bcount_next, 1'b0});
               prev_in             = pos_ff;
               pos_in              = pos_ff + POS_W'(2) + POS_W'(len_ff);
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr_l[AW-1:0]] <= head.entry.data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[raddr_l[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      is_read_ff <= is_read_in;
      len_hi_ff  <= len_hi_in;
      len_ff     <= len_in;
      baddr_ff   <= baddr_in;
      bcount_ff  <= bcount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         prev_ff  <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         prev_ff  <= prev_in;
         rsp_ff   <= rsp_in;
      end
   end

endmodule

// ----- rtl/tape_record_controller.sv -----
// ----------------------------------------------------------------------------
// tape_record_controller
// Tape controller over a byte reel image: load, rewind, space, read records.
//
//   channel   ports                              handshake
//   request   req_operation/order/address/data   start high, busy low
//   result    rsp_status/nibble/nibble_valid/    rsp_valid, one cycle
//             rsp_nibble_count/rsp_last
//   config    csr_index, csr_wdata               csr_write
//
// Loads and plain commands complete in the back part's idle state. Forward space
// first reads the two length bytes through the single image port.
// A read does likewise, then sends each record byte as two nibbles, high first,
// one nibble a cycle. A four-word queue decouples the request side from the image port.
// Reset clears positions, state and queue pointers and resets the config registers;
// the image is undefined until loaded. Results cannot be stalled; busy rises only when the queue is full.
// ----------------------------------------------------------------------------
module tape_record_controller #(
   parameter int IMAGE_BYTES      = 1048576,
   parameter int MAX_READ_NIBBLES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [trc_pkg::OP_W-1:0]        req_operation,
   input  logic [trc_pkg::ORDER_W-1:0]     req_order,
   input  logic [trc_pkg::ADDR_W-1:0]      req_address,
   input  logic [trc_pkg::DATA_W-1:0]      req_data,
   output logic                            rsp_valid,
   output logic [trc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [trc_pkg::NIB_W-1:0]       rsp_nibble,
   output logic                            rsp_nibble_valid,
   output logic [trc_pkg::COUNT_W-1:0]     rsp_nibble_count,
   output logic                            rsp_last,
   input  logic                            csr_write,
   input  logic [trc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [trc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import trc_pkg::*;

   logic [POS_W-1:0]  image_length_ff;
   logic [POS_W-1:0]  image_length_in;
   logic [CAP_W-1:0]  read_capacity_ff;
   logic [CAP_W-1:0]  read_capacity_in;

   logic       full;
   logic       push;
   entry_type  push_entry;
   head_type   head;
   logic       pop;
   rsp_type    rsp;

   always_comb begin
      image_length_in  = image_length_ff;
      read_capacity_in = read_capacity_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_LENGTH: begin
               image_length_in = csr_wdata[POS_W-1:0];
            end
            CSR_READ_CAPACITY: begin
               read_capacity_in = csr_wdata[CAP_W-1:0];
            end
            default: begin
               image_length_in = image_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_length_ff  <= '0;
         read_capacity_ff <= CAP_RESET;
      end else begin
         image_length_ff  <= image_length_in;
         read_capacity_ff <= read_capacity_in;
      end
   end

   trc_front u_front (
      .start         (start),
      .full          (full),
      .req_operation (req_operation),
      .req_order     (req_order),
      .req_address   (req_address),
      .req_data      (req_data),
      .busy          (busy),
      .push          (push),
      .push_entry    (push_entry)
   );

   trc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full)
   );

   trc_back #(
      .IMAGE_BYTES      (IMAGE_BYTES),
      .MAX_READ_NIBBLES (MAX_READ_NIBBLES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .image_length  (image_length_ff),
      .read_capacity (read_capacity_ff),
      .pop           (pop),
      .rsp           (rsp)
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_status       = rsp.status;
   assign rsp_nibble       = rsp.nibble;
   assign rsp_nibble_valid = rsp.nibble_valid;
   assign rsp_nibble_count = rsp.nibble_count;
   assign rsp_last         = rsp.last;

`ifndef SYNTH
   a_nibble_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nibble_valid |-> rsp_status == ST_END)
      else $error("nibble word with status other than end");

   a_mid_is_nibble: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_nibble_valid)
      else $error("non-final word carries no nibble");

   a_count_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_nibble_valid
      |-> rsp_nibble_count != '0 && !rsp_nibble_count[0])
      else $error("bad nibble count on final word");

   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted word");
`endif

endmodule
